// ===== src/ppmfg_pkg.sv =====
// ---------------------------------------------------------------------------
// ppmfg_pkg - shared types and constants of the PPM frame generator
// Command codes, phase codes, channel width limits and reset values of the
// configuration registers.
// ---------------------------------------------------------------------------
package ppmfg_pkg;

  // Request kinds carried in the slave-side tuser
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  // Pulse train phases
  typedef enum logic [1:0] {
    PH_CH_HI = 2'd0,
    PH_CH_LO = 2'd1,
    PH_SY_HI = 2'd2,
    PH_SY_LO = 2'd3
  } phase_e;

  // Configuration register indexes (paddr bit 2)
  localparam logic REG_PULSE = 1'b0;
  localparam logic REG_FRAME = 1'b1;

  localparam int unsigned NUM_CHANNELS_DEF = 8;

  localparam int unsigned WW = 11;  // channel width bits
  localparam int unsigned PW = 10;  // pulse length bits
  localparam int unsigned FW = 16;  // frame length / tick counter bits

  localparam logic [WW-1:0] WIDTH_MIN = 11'd1000;
  localparam logic [WW-1:0] WIDTH_MAX = 11'd2000;

  localparam logic [PW-1:0] PULSE_RST = 10'd300;
  localparam logic [FW-1:0] FRAME_RST = 16'd22500;

endpackage

// ===== src/ppm_frame_generator.sv =====
// ---------------------------------------------------------------------------
// ppm_frame_generator - RC PPM pulse train generator
// Each tick request advances the pulse train by one microsecond. Channel
// slots run high for pulse_length ticks and low for the rest of the channel
// width; a sync gap pads the frame out to frame_length.
//
// Usage:
//  - Slave stream: one request per item. tuser holds the command (tick,
//    write channel, disarm all, read channel); tdata holds channel_index and
//    channel_value.
//  - Master stream: one result per request with the line level, a frame
//    start flag and the read-back value.
//  - APB port: pulse_length at 0x0, frame_length at 0x4. Write only while
//    the block is idle.
//  - Throughput: one request per cycle while the result receiver keeps up. The
//    channel widths sit in a small synchronous memory read at acceptance;
//    the phase logic works on the request held in the working stage, and
//    its result is registered in the output register, from which it leaves.
//  - When the receiver stalls, the output register holds and one more
//    request is taken into the working stage before tready drops.
//  - Reset empties the pipeline, sets every channel to 1000 ticks, restarts
//    the frame at slot 0 and loads the register defaults.
// ---------------------------------------------------------------------------
module ppm_frame_generator
  import ppmfg_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] channel_index, [15:4] channel_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] pin_level, [11:1] read_value, rest zero
  output logic [0:0]  m_axis_tuser,   // [0] frame_start
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_CHANNELS - 1);

  typedef struct packed {
    phase_e          phase;
    logic [AW-1:0]   slot;
    logic [FW-1:0]   left;
    logic [FW-1:0]   used;
    logic [WW-1:0]   width;
  } st_t;

  // Slot that follows s in the frame
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    next_slot = (s == LAST) ? '0 : AW'(s + 1'b1);
  endfunction

  // One phase transition; w_new is the width of the slot that would begin
  function automatic st_t next_phase(input st_t s, input logic [PW-1:0] pl,
                                     input logic [FW-1:0] fl,
                                     input logic [WW-1:0] w_new);
    st_t           r;
    logic [FW-1:0] rest;
    logic          begin_slot;
    r          = s;
    rest       = (fl > s.used) ? FW'(fl - s.used) : '0;
    begin_slot = 1'b0;
    unique case (s.phase)
      PH_CH_HI: begin
        r.phase = PH_CH_LO;
        r.left  = (s.width > WW'(pl)) ? FW'(s.width - WW'(pl)) : '0;
      end
      PH_CH_LO: begin
        if (s.slot != LAST) begin
          begin_slot = 1'b1;
        end else if (rest > FW'(pl)) begin
          r.phase = PH_SY_HI;
          r.left  = FW'(pl);
        end else begin
          r.used     = '0;
          begin_slot = 1'b1;
        end
      end
      PH_SY_HI: begin
        r.phase = PH_SY_LO;
        r.left  = rest;
      end
      PH_SY_LO: begin
        r.used     = '0;
        begin_slot = 1'b1;
      end
    endcase
    if (begin_slot) begin
      r.slot  = next_slot(s.slot);
      r.phase = PH_CH_HI;
      r.width = w_new;
      r.left  = FW'(pl);
    end
    return r;
  endfunction

  // ---- configuration registers ----
  logic [PW-1:0] pulse_q;
  logic [FW-1:0] frame_q;
  logic          cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= PULSE_RST;
      frame_q <= FRAME_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PULSE) begin
        pulse_q <= pwdata[PW-1:0];
      end else begin
        frame_q <= pwdata[FW-1:0];
      end
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = (paddr[2] == REG_FRAME) ? 32'(frame_q) : 32'(pulse_q);
  end

  // ---- input decode ----
  cmd_e          in_cmd;
  logic [3:0]    in_idx;
  logic [11:0]   in_val;
  logic          in_idx_ok;
  logic          in_acc;

  assign in_cmd    = cmd_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[3:0];
  assign in_val    = s_axis_tdata[15:4];
  assign in_idx_ok = {1'b0, in_idx} < 5'(NUM_CHANNELS);
  assign in_acc    = s_axis_tvalid & s_axis_tready;

  // ---- channel width memory with per-entry valid bits ----
  logic [WW-1:0]           mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  logic [AW-1:0]           addr_a;
  logic [AW-1:0]           addr_b;
  logic                    wr_en;

  st_t                     st_q;
  st_t                     st_d;

  // Port A serves reads or the next slot to begin; port B the one after it
  assign addr_a = (in_cmd == CMD_READ) ? in_idx[AW-1:0] : next_slot(st_q.slot);
  assign addr_b = next_slot(next_slot(st_q.slot));
  assign wr_en  = in_acc && (in_cmd == CMD_WRITE) && in_idx_ok &&
                  (in_val >= 12'(WIDTH_MIN)) && (in_val <= 12'(WIDTH_MAX));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[in_idx[AW-1:0]] <= in_val[WW-1:0];
    end
  end

  // Set on write, clear on disarm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (in_acc && (in_cmd == CMD_DISARM)) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[in_idx[AW-1:0]] <= 1'b1;
    end
  end

  // ---- working stage ----
  logic          s1_v_q;
  cmd_e          s1_cmd_q;
  logic          s1_ok_q;
  logic [AW-1:0] s1_slot_q;
  logic [WW-1:0] rd_a_q;
  logic [WW-1:0] rd_b_q;
  logic          vld_a_q;
  logic          vld_b_q;
  logic          s1_adv;
  logic          out_v_q;

  assign s1_adv        = s1_v_q & (~out_v_q | m_axis_tready);
  assign s_axis_tready = ~s1_v_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  // Capture the request and the registered memory read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= in_cmd;
      s1_ok_q   <= in_idx_ok;
      s1_slot_q <= st_q.slot;
      rd_a_q    <= mem_q[addr_a];
      rd_b_q    <= mem_q[addr_b];
      vld_a_q   <= vld_q[addr_a];
      vld_b_q   <= vld_q[addr_b];
    end
  end

  // ---- tick processing ----
  logic [WW-1:0] width_a;
  logic [WW-1:0] width_b;
  logic [WW-1:0] w_new;
  st_t           lp1;
  st_t           tk;
  logic          tk_fstart;
  logic          tk_level;
  logic          level_q;
  logic          level_d;
  logic          is_tick;

  assign width_a = vld_a_q ? rd_a_q : WIDTH_MIN;
  assign width_b = vld_b_q ? rd_b_q : WIDTH_MIN;
  // Port B applies if the previous request already began a slot
  assign w_new   = (st_q.slot == s1_slot_q) ? width_a : width_b;
  assign is_tick = (s1_cmd_q == CMD_TICK);

  always_comb begin
    // Skip a zero-length phase
    lp1 = (st_q.left == '0) ? next_phase(st_q, pulse_q, frame_q, w_new) : st_q;

    tk_fstart = (lp1.used == '0);
    tk_level  = (lp1.phase == PH_CH_HI) || (lp1.phase == PH_SY_HI);

    // Spend the tick, then move on if the phase ran out
    tk = lp1;
    if (tk.left != '0) begin
      tk.left = FW'(tk.left - 1'b1);
    end
    if (tk.used != '1) begin
      tk.used = FW'(tk.used + 1'b1);
    end
    if (tk.left == '0) begin
      tk = next_phase(tk, pulse_q, frame_q, w_new);
    end
  end

  always_comb begin
    st_d    = st_q;
    level_d = level_q;
    if (s1_adv && is_tick) begin
      st_d    = tk;
      level_d = tk_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase <= PH_CH_HI;
      st_q.slot  <= '0;
      st_q.left  <= FW'(PULSE_RST);
      st_q.used  <= '0;
      st_q.width <= WIDTH_MIN;
      level_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      level_q <= level_d;
    end
  end

  // ---- output register ----
  logic          out_pin_q;
  logic          out_fs_q;
  logic [WW-1:0] out_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (~out_v_q | m_axis_tready) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pin_q <= is_tick ? tk_level : level_q;
      out_fs_q  <= is_tick & tk_fstart;
      out_rd_q  <= ((s1_cmd_q == CMD_READ) && s1_ok_q) ? width_a : '0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0, out_rd_q, out_pin_q};
  assign m_axis_tuser  = out_fs_q;

  // ---- assertions ----
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.slot <= LAST)
    else $error("slot number beyond last channel");

  a_disarm_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_cmd == CMD_DISARM)) |=> (vld_q == '0))
    else $error("disarm left a channel written");

  a_non_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !is_tick) |=> (st_q == $past(st_q)))
    else $error("non-tick request moved the pulse train");

  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && is_tick) |-> (lp1.left != '0))
    else $error("zero-length phases not resolved");

endmodule

// ===== verif/ppm_frame_checker.sv =====
// ---------------------------------------------------------------------------
// ppm_frame_checker - scoreboard for the PPM frame generator
// Watches the request stream, the result stream and the APB port. Keeps its
// own copy of the pulse train state, channel widths and registers, predicts
// one line result per accepted request and compares results in order.
// ---------------------------------------------------------------------------
module ppm_frame_checker
  import ppmfg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] channel_index, [15:4] channel_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [0] pin_level, [11:1] read_value, rest zero
  input  logic [0:0]  m_axis_tuser,   // [0] frame_start
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCH        = NUM_CHANNELS_DEF;
  localparam int unsigned SKIP_LIMIT = 4 * NCH + 8;
  localparam int          PRINT_MAX  = 50;

  typedef struct packed {
    logic          pin;
    logic          fstart;
    logic [WW-1:0] rd;
  } line_result_t;

  // Shadow registers
  logic [PW-1:0] pulse_q;
  logic [FW-1:0] frame_q;

  // Shadow pulse train state
  logic [WW-1:0] width_mem [NCH];
  int unsigned   slot_q;
  phase_e        phase_q;
  logic [FW-1:0] ticks_left_q;
  logic [FW-1:0] used_q;
  logic [WW-1:0] slot_w_q;
  logic          line_q;

  line_result_t  expected_lines [$];

  // Ticks left before the frame period is used up
  function automatic logic [FW-1:0] frame_room();
    return (frame_q > used_q) ? frame_q - used_q : '0;
  endfunction

  // Start a slot and latch its width
  function automatic void open_slot(int unsigned s);
    slot_q       = s;
    phase_q      = PH_CH_HI;
    slot_w_q     = width_mem[s];
    ticks_left_q = FW'(pulse_q);
  endfunction

  // Move to the next phase of the pulse train
  function automatic void advance_phase();
    case (phase_q)
      PH_CH_HI: begin
        phase_q      = PH_CH_LO;
        ticks_left_q = (slot_w_q > pulse_q) ? FW'(slot_w_q - WW'(pulse_q)) : '0;
      end
      PH_CH_LO: begin
        if (slot_q + 1 < NCH) begin
          open_slot(slot_q + 1);
        end else if (frame_room() > FW'(pulse_q)) begin
          phase_q      = PH_SY_HI;
          ticks_left_q = FW'(pulse_q);
        end else begin
          used_q = '0;
          open_slot(0);
        end
      end
      PH_SY_HI: begin
        phase_q      = PH_SY_LO;
        ticks_left_q = frame_room();
      end
      default: begin
        used_q = '0;
        open_slot(0);
      end
    endcase
  endfunction

  // Apply one request to the shadow state and return the line result
  function automatic line_result_t predict_line(cmd_e cmd, logic [3:0] idx,
                                                logic [11:0] val);
    line_result_t res;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        // skip phases of zero length without spending a tick
        for (int i = 0; ticks_left_q == '0 && i < SKIP_LIMIT; i++) advance_phase();
        res.fstart = (used_q == '0);
        line_q     = (phase_q == PH_CH_HI) || (phase_q == PH_SY_HI);
        if (ticks_left_q != '0) ticks_left_q--;
        if (used_q != '1) used_q++;
        if (ticks_left_q == '0) advance_phase();
      end
      CMD_WRITE: begin
        if (idx < NCH && val >= WIDTH_MIN && val <= WIDTH_MAX) width_mem[idx] = val[WW-1:0];
      end
      CMD_DISARM: begin
        foreach (width_mem[i]) width_mem[i] = WIDTH_MIN;
      end
      default: begin
        if (idx < NCH) res.rd = width_mem[idx];
      end
    endcase
    res.pin = line_q;
    return res;
  endfunction

  // Print a mismatch line while fewer than PRINT_MAX were seen, and count it
  task automatic report_mismatch(input string what);
    if (fail_count_o < PRINT_MAX) $display("%0t ppm_frame_checker: %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_result_t want;
    logic [31:0]  reg_want;
    if (!rst_ni) begin
      pulse_q = PULSE_RST;
      frame_q = FRAME_RST;
      foreach (width_mem[i]) width_mem[i] = WIDTH_MIN;
      used_q  = '0;
      line_q  = 1'b0;
      open_slot(0);
      expected_lines.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // compare the result leaving the block
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_lines.pop_front();
          if (m_axis_tdata[0] !== want.pin)
            report_mismatch($sformatf("pin_level got %b, want %b", m_axis_tdata[0], want.pin));
          if (m_axis_tuser[0] !== want.fstart)
            report_mismatch($sformatf("frame_start got %b, want %b", m_axis_tuser[0],
                                      want.fstart));
          if (m_axis_tdata[11:1] !== want.rd)
            report_mismatch($sformatf("read_value got %0d, want %0d", m_axis_tdata[11:1],
                                      want.rd));
          if (m_axis_tdata[15:12] !== 4'd0)
            report_mismatch($sformatf("tdata pad bits got %h", m_axis_tdata[15:12]));
        end
      end

      // predict the result of an accepted request
      if (s_axis_tvalid && s_axis_tready)
        expected_lines.push_back(predict_line(cmd_e'(s_axis_tuser), s_axis_tdata[3:0],
                                              s_axis_tdata[15:4]));

      // track register writes and check read-back
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_PULSE) pulse_q = pwdata[PW-1:0];
          else                       frame_q = pwdata[FW-1:0];
        end else begin
          reg_want = (paddr[2] == REG_PULSE) ? 32'(pulse_q) : 32'(frame_q);
          if (prdata !== reg_want)
            report_mismatch($sformatf("prdata at %h got %0d, want %0d", paddr, prdata,
                                      reg_want));
        end
      end

      pending_o = expected_lines.size();
    end
  end

endmodule

// ===== verif/ppm_frame_generator_tb.sv =====
// ---------------------------------------------------------------------------
// ppm_frame_generator_tb - top level testbench of the PPM frame generator
// Drives tick, write, disarm and read requests and APB register settings,
// with random source gaps and sink stalls. A checker module beside the block
// predicts and compares every result; this module gives the verdict.
// ---------------------------------------------------------------------------
module ppm_frame_generator_tb;
  import ppmfg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [3:0] channel_index, [15:4] channel_value
  logic [1:0]  s_axis_tuser  = CMD_TICK;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;   // [0] pin_level, [11:1] read_value, rest zero
  logic [0:0]  m_axis_tuser;   // [0] frame_start
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int gap_pct   = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  ppm_frame_generator u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ppm_frame_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // Stall the result sink at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ppm_frame_generator_tb: FAIL");
      $finish;
    end
  end

  // Present one request and hold it until accepted; returns at a falling edge
  task automatic send_request(input cmd_e cmd, input logic [3:0] idx,
                              input logic [11:0] val);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly ticks; the rest writes, reads and the odd disarm
  task automatic random_request(input int tick_pct);
    int          pick;
    logic [3:0]  idx;
    logic [11:0] val;
    pick = $urandom_range(99);
    idx  = ($urandom_range(4) != 0) ? 4'($urandom_range(NUM_CHANNELS_DEF - 1))
                                    : 4'($urandom_range(15));
    val  = ($urandom_range(3) != 0) ? 12'($urandom_range(2000, 1000))
                                    : 12'($urandom_range(4095));
    if (pick < tick_pct) begin
      send_request(CMD_TICK, 4'($urandom), 12'($urandom));
    end else begin
      pick = $urandom_range(19);
      if (pick == 0)      send_request(CMD_DISARM, idx, val);
      else if (pick < 11) send_request(CMD_WRITE, idx, val);
      else                send_request(CMD_READ, idx, val);
    end
  endtask

  // Drop valid and wait until every result has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access cycle
  task automatic apb_access(input logic wr, input logic reg_sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Set both registers, read them back, then run random requests
  task automatic run_phase(input int pulse, input int frame, input int gap,
                           input int stall, input int count, input int tick_pct);
    settle();
    gap_pct   = 0;
    stall_pct = 0;
    apb_access(1'b1, REG_PULSE, 32'(pulse));
    apb_access(1'b0, REG_PULSE, '0);
    apb_access(1'b1, REG_FRAME, 32'(frame));
    apb_access(1'b0, REG_FRAME, '0);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) random_request(tick_pct);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset defaults, range limits of writes, bad indexes, disarm
    apb_access(1'b0, REG_PULSE, '0);
    apb_access(1'b0, REG_FRAME, '0);
    send_request(CMD_TICK, 4'd0, 12'd0);
    send_request(CMD_TICK, 4'd0, 12'd0);
    send_request(CMD_TICK, 4'hF, 12'hFFF);
    send_request(CMD_READ, 4'd0, 12'd0);
    send_request(CMD_READ, 4'd7, 12'd0);
    send_request(CMD_READ, 4'd8, 12'd0);
    send_request(CMD_READ, 4'd15, 12'hFFF);
    send_request(CMD_WRITE, 4'd7, 12'd2000);
    send_request(CMD_WRITE, 4'd0, 12'd1000);
    send_request(CMD_WRITE, 4'd3, 12'd999);
    send_request(CMD_WRITE, 4'd3, 12'd2001);
    send_request(CMD_WRITE, 4'd2, 12'hFFF);
    send_request(CMD_WRITE, 4'd2, 12'd0);
    send_request(CMD_WRITE, 4'd8, 12'd1500);
    send_request(CMD_WRITE, 4'd15, 12'd1500);
    send_request(CMD_WRITE, 4'd5, 12'd1234);
    send_request(CMD_READ, 4'd7, 12'd0);
    send_request(CMD_READ, 4'd3, 12'd0);
    send_request(CMD_READ, 4'd5, 12'd0);
    send_request(CMD_READ, 4'd2, 12'd0);
    send_request(CMD_DISARM, 4'd0, 12'd0);
    send_request(CMD_READ, 4'd7, 12'd0);
    send_request(CMD_TICK, 4'd0, 12'd0);

    // Random: tick runs cross slot ends, short runs carry idling
    run_phase(300, 22500, 0, 0, 400, 99);
    run_phase(1, 9000, 80, 0, 250, 85);
    run_phase(999, 1, 0, 0, 400, 99);
    run_phase(500, 65535, 0, 80, 250, 85);
    settle();
    send_request(CMD_DISARM, 4'd0, 12'd0);
    run_phase(1, 8200, 0, 0, 200, 99);
    run_phase(999, 12000, 14, 14, 200, 90);
    run_phase(650, 16000, 0, 0, 50, 70);
    run_phase(300, 22500, 14, 14, 50, 80);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ppm_frame_generator_tb: PASS");
    end else begin
      $display("ppm_frame_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
